[src/stream_find_replace_macros.svh]
// Assertion macros shared by the find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define SFR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("stream_find_replace assertion failed");
// Condition that must hold in the cycle after the trigger.
`define SFR_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("stream_find_replace assertion failed");
`else
`define SFR_ASSERT(label, cond)
`define SFR_ASSERT_NEXT(label, trig, cond)
`endif
`endif

[src/sfr_pkg.sv]
// Types and constants shared by the find-and-replace modules.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned MAX_REPLACE = 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned IDX_W       = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Active configuration, lengths already clamped to 1..max
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat;
    logic [LEN_W-1:0]                   plen;
    logic [MAX_REPLACE-1:0][BYTE_W-1:0] rep;
    logic [LEN_W-1:0]                   rlen;
  } cfg_t;

  // One run of result bytes caused by a single input byte
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]                   count;
    logic                               eof;
  } run_t;

  // Clamp a raw length to 1..max
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                 input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] res;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > max_len) begin
      res = max_len;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

[src/sfr_config.sv]
// Configuration registers for pattern and replacement.
`timescale 1ns / 1ps
module sfr_config (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  output sfr_pkg::cfg_t                 cfg,
  output logic                          pattern_clear
);

  logic [sfr_pkg::CFG_DATA_W-1:0] pattern_bytes;
  logic [sfr_pkg::LEN_W-1:0]      pattern_length;
  logic [sfr_pkg::CFG_DATA_W-1:0] replacement_bytes;
  logic [sfr_pkg::LEN_W-1:0]      replacement_length;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= sfr_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= sfr_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Any pattern write drops the held prefix
  assign pattern_clear = cfg_we && ((cfg_index == sfr_pkg::REG_PATTERN_BYTES) ||
                                    (cfg_index == sfr_pkg::REG_PATTERN_LENGTH));

  assign cfg.pat  = pattern_bytes;
  assign cfg.plen = sfr_pkg::clamp_len(pattern_length, sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN));
  assign cfg.rep  = replacement_bytes;
  assign cfg.rlen = sfr_pkg::clamp_len(replacement_length,
                                       sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE));

endmodule

[src/sfr_match.sv]
// Input register, prefix matcher and matched-count state.
`timescale 1ns / 1ps
`include "stream_find_replace_macros.svh"
module sfr_match (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] in_byte
  input  logic                  s_tlast,  // end_of_file
  input  sfr_pkg::cfg_t         cfg,
  input  logic                  pattern_clear,
  input  logic                  can_load,
  output logic                  load,
  output sfr_pkg::run_t         run
);

  localparam int unsigned NP = sfr_pkg::MAX_PATTERN;
  localparam int unsigned LW = sfr_pkg::LEN_W;

  logic                  in_valid;
  sfr_pkg::byte_t        in_byte;
  logic                  in_eof;
  logic [LW-1:0]         mc;
  logic [LW-1:0]         mc_next;
  logic [LW-1:0]         held;
  logic [LW-1:0]         n;
  logic [LW-1:0]         drop;
  logic [LW-1:0]         rem;
  logic                  full;
  logic                  advance;
  logic [NP-1:0]         cand;
  logic [NP-1:0][NP-1:0] term;
  logic [NP-1:0][7:0]    buf_bytes;

  // Held bytes are a pattern prefix; stale counts restart at zero
  assign held = (mc >= cfg.plen) ? '0 : mc;
  assign n    = held + LW'(1);

  // Drop candidate d: held pattern bytes from d on, then the new byte,
  // must spell a pattern prefix no longer than the pattern
  for (genvar d = 0; d < NP; d++) begin : g_drop
    for (genvar i = 0; i < NP; i++) begin : g_pos
      if (d + i < NP) begin : g_in
        assign term[d][i] = (LW'(d + i) < held)  ? (cfg.pat[d + i] == cfg.pat[i]) :
                            (LW'(d + i) == held) ? (in_byte == cfg.pat[i]) : 1'b1;
      end else begin : g_out
        assign term[d][i] = 1'b1;
      end
    end
    assign cand[d] = (LW'(d) <= held) && ((n - LW'(d)) <= cfg.plen) && (&term[d]);
  end

  // Fewest dropped bytes wins; none fits means everything drops
  always_comb begin
    drop = n;
    for (int d = NP - 1; d >= 0; d--) begin
      if (cand[d]) begin
        drop = LW'(d);
      end
    end
  end

  assign rem  = n - drop;
  assign full = (rem == cfg.plen);

  // Held bytes followed by the new byte
  for (genvar j = 0; j < NP; j++) begin : g_buf
    assign buf_bytes[j] = (LW'(j) < held) ? cfg.pat[j] : in_byte;
  end

  // Result run: replacement on a full match, else dropped bytes (all on eof)
  always_comb begin
    if (full) begin
      run.bytes = cfg.rep;
      run.count = cfg.rlen;
    end else begin
      run.bytes = buf_bytes;
      run.count = in_eof ? n : drop;
    end
    run.eof = in_eof;
    mc_next = (full || in_eof) ? '0 : rem;
  end

  // Handshake: an item with no result never waits on the emitter
  assign advance  = in_valid && ((run.count == '0) || can_load);
  assign load     = advance && (run.count != '0);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eof  <= s_tlast;
    end
  end

  // Matched count
  always_ff @(posedge clk) begin
    if (rst) begin
      mc <= '0;
    end else if (pattern_clear) begin
      mc <= '0;
    end else if (advance) begin
      mc <= mc_next;
    end
  end

  `SFR_ASSERT(a_mc_below_len, mc < cfg.plen)
  `SFR_ASSERT_NEXT(a_eof_clears, advance && in_eof, mc == '0)

endmodule

[src/sfr_emit.sv]
// Result register that plays out one run of bytes, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`include "stream_find_replace_macros.svh"
module sfr_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sfr_pkg::run_t run,
  output logic          can_load,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,  // [7:0] out_byte
  output logic          m_tlast,  // last_of_run
  output logic          m_tuser   // end_of_output
);

  localparam int unsigned LW = sfr_pkg::LEN_W;
  localparam int unsigned IW = sfr_pkg::IDX_W;

  logic                                       run_valid;
  logic [sfr_pkg::MAX_PATTERN-1:0][7:0]       run_bytes;
  logic [LW-1:0]                              run_count;
  logic                                       run_eof;
  logic [IW-1:0]                              idx;
  logic                                       last;

  assign last     = ({1'b0, idx} == (run_count - LW'(1)));
  assign can_load = !run_valid || (m_tready && last);

  // Run state and byte pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (run_valid && m_tready) begin
      if (last) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (load) begin
      run_bytes <= run.bytes;
      run_count <= run.count;
      run_eof   <= run.eof;
    end
  end

  assign m_tvalid = run_valid;
  assign m_tdata  = run_bytes[idx];
  assign m_tlast  = last;
  assign m_tuser  = last && run_eof;

  `SFR_ASSERT(a_idx_in_run, !run_valid || ({1'b0, idx} < run_count))
  `SFR_ASSERT(a_load_when_free, !load || can_load)

endmodule

[src/stream_find_replace.sv]
// Top level of the streaming find-and-replace block.
`timescale 1ns / 1ps
// Streaming find-and-replace. Bytes enter on the s_ stream (tdata = in_byte,
// tlast = end_of_file) and the rewritten text leaves on the m_ stream
// (tdata = out_byte, tlast = last byte caused by one input byte, tuser = very
// last byte of the text). Each leftmost, non-overlapping occurrence of the
// pattern is replaced; partial matches are held and flushed at end of file.
// Pattern, replacement and their lengths (1..8) are written through the
// cfg_we / cfg_index / cfg_data port while the stream is idle; a pattern
// write drops any held partial match.
// A byte taken into the input register moves on into the result register once
// that register is free, and its first result then appears on the m_ stream.
// The block takes one input byte per cycle while the result register is free;
// a byte with result bytes (0 to 8) holds the output until all of them are
// out, since the result register plays out one byte per cycle while the
// receiver is ready. Bytes with no result pass freely.
// Reset (rst, synchronous) empties both registers, clears the match count and
// restores pattern and replacement to one zero byte each. When the receiver
// stalls, the result register holds its byte and the input side stops once
// the input register is also full.
module stream_find_replace (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] in_byte
  input  logic                           s_tlast,  // end_of_file
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [7:0] out_byte
  output logic                           m_tlast,  // last_of_run
  output logic                           m_tuser,  // end_of_output
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::run_t run;
  logic          pattern_clear;
  logic          can_load;
  logic          load;

  sfr_config u_config (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .pattern_clear (pattern_clear)
  );

  sfr_match u_match (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .cfg           (cfg),
    .pattern_clear (pattern_clear),
    .can_load      (can_load),
    .load          (load),
    .run           (run)
  );

  sfr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .run      (run),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[bench/tb.sv]
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 1ps
// Bytes go in on the s_ stream and every rewritten byte that comes out on the
// m_ stream is checked against a predictor of the block. A directed script
// runs first: reset values, extremes, length clamping, overlap and a pattern
// rewrite mid-stream. Random phases with fresh settings follow. Both sides
// idle in short random bursts, and the receiver holds off once for a long
// stretch so that the block backs up into its input.
module tb;

  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 16;

  // One output byte as the block should present it
  typedef struct packed {
    sfr_pkg::byte_t data;
    logic           last;
    logic           eoo;
  } result_t;

  // One line of the directed script: a register write or an input byte
  typedef struct {
    bit             is_reg;
    logic [1:0]     idx;
    logic [63:0]    val;
    sfr_pkg::byte_t data;
    logic           eof;
    int             n_typed;  // -1: take results from the predictor
    logic [63:0]    typed;    // typed result bytes, byte i at 8i+7..8i
  } step_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = sfr_pkg::REG_PATTERN_BYTES;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the match count
  logic [63:0] pat_word;
  logic [3:0]  pat_len_raw;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_raw;
  int          held_cnt;

  result_t     pending_out[$];
  int          errors       = 0;
  int          cycle_count  = 0;
  bit          send_gaps    = 1'b1;
  bit          recv_stalls  = 1'b1;
  bit          stall_long   = 1'b0;
  bit          stall_served = 1'b0;

  stream_find_replace DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // Clamped pattern length in use
  function automatic int pat_len();
    int res;
    if (pat_len_raw == 0) res = 1;
    else if (pat_len_raw > sfr_pkg::MAX_PATTERN) res = sfr_pkg::MAX_PATTERN;
    else res = int'(pat_len_raw);
    return res;
  endfunction

  // Rewrite one input byte: results it causes, match count updated
  function automatic void rewrite_byte(input sfr_pkg::byte_t b, input logic eof,
                                       output result_t res[$]);
    int             plen;
    int             rlen;
    int             held;
    int             n;
    int             drop;
    int             rem;
    int             i;
    bit             ok;
    sfr_pkg::byte_t win [0:sfr_pkg::MAX_PATTERN];
    result_t        r;
    res  = {};
    plen = pat_len();
    if (rep_len_raw == 0) rlen = 1;
    else if (rep_len_raw > sfr_pkg::MAX_REPLACE) rlen = sfr_pkg::MAX_REPLACE;
    else rlen = int'(rep_len_raw);
    held = (held_cnt >= plen) ? 0 : held_cnt;
    for (i = 0; i < held; i++) win[i] = pat_word[8*i +: 8];
    win[held] = b;
    n = held + 1;
    // fewest leading bytes to drop so the rest is still a pattern prefix
    for (drop = 0; drop < n; drop++) begin
      rem = n - drop;
      if (rem > plen) continue;
      ok = 1'b1;
      for (i = 0; i < rem; i++) begin
        if (win[drop + i] != pat_word[8*i +: 8]) ok = 1'b0;
      end
      if (ok) break;
    end
    rem    = n - drop;
    r.last = 1'b0;
    r.eoo  = 1'b0;
    for (i = 0; i < drop; i++) begin
      r.data = win[i];
      res.push_back(r);
    end
    if (rem == plen) begin
      for (i = 0; i < rlen; i++) begin
        r.data = rep_word[8*i +: 8];
        res.push_back(r);
      end
      held_cnt = 0;
    end else begin
      held_cnt = rem;
    end
    // end of file flushes the held prefix
    if (eof) begin
      for (i = 0; i < held_cnt; i++) begin
        r.data = pat_word[8*i +: 8];
        res.push_back(r);
      end
      held_cnt = 0;
    end
    if (res.size() > 0) begin
      r      = res[res.size() - 1];
      r.last = 1'b1;
      r.eoo  = eof;
      res[res.size() - 1] = r;
    end
  endfunction

  // Offer one byte and wait for its transaction
  task automatic send_byte(input sfr_pkg::byte_t b, input logic eof);
    bit taken;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eof;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
  endtask

  // Send a byte and queue what it must produce
  task automatic feed(input sfr_pkg::byte_t b, input logic eof, input int n_typed,
                      input logic [63:0] typed);
    result_t res[$];
    result_t r;
    int      i;
    send_byte(b, eof);
    rewrite_byte(b, eof, res);
    if (n_typed >= 0) begin
      res = {};
      for (i = 0; i < n_typed; i++) begin
        r.data = typed[8*i +: 8];
        r.last = (i == n_typed - 1);
        r.eoo  = r.last & eof;
        res.push_back(r);
      end
    end
    for (i = 0; i < res.size(); i++) pending_out.push_back(res[i]);
  endtask

  // Stop offering, let every result out, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only once the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES: begin
        pat_word = val;
        held_cnt = 0;
      end
      sfr_pkg::REG_PATTERN_LENGTH: begin
        pat_len_raw = val[3:0];
        held_cnt    = 0;
      end
      sfr_pkg::REG_REPLACEMENT_BYTES:  rep_word    = val;
      sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_raw = val[3:0];
      default: ;
    endcase
  endtask

  function automatic step_t reg_step(input logic [1:0] idx, input logic [63:0] val);
    step_t s;
    s.is_reg  = 1'b1;
    s.idx     = idx;
    s.val     = val;
    s.data    = '0;
    s.eof     = 1'b0;
    s.n_typed = -1;
    s.typed   = '0;
    return s;
  endfunction

  function automatic step_t byte_step(input sfr_pkg::byte_t d, input logic eof,
                                      input int n_typed, input logic [63:0] typed);
    step_t s;
    s.is_reg  = 1'b0;
    s.idx     = sfr_pkg::REG_PATTERN_BYTES;
    s.val     = '0;
    s.data    = d;
    s.eof     = eof;
    s.n_typed = n_typed;
    s.typed   = typed;
    return s;
  endfunction

  // Receiver: short random stalls, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (stall_long && !stall_served) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        stall_served = 1'b1;
      end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Output checker: values are stable from the falling edge to the transaction
  initial begin
    result_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_out.size() == 0) begin
          $error("unexpected result: out_byte %h", m_tdata);
          errors++;
        end else begin
          want = pending_out.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_tlast);
            errors++;
          end
          if (m_tuser !== want.eoo) begin
            $error("end_of_output: expected %b, got %b", want.eoo, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    step_t          script[$];
    sfr_pkg::byte_t text[$];
    sfr_pkg::byte_t sym_a;
    sfr_pkg::byte_t sym_b;
    logic [63:0]    word;
    logic           eof;
    int             i;
    int             k;
    int             j;
    int             plen;
    int             phase;
    int             pick;

    pat_word    = '0;
    pat_len_raw = 4'd1;
    rep_word    = '0;
    rep_len_raw = 4'd1;
    held_cnt    = 0;

    // after reset: one zero byte replaced by one zero byte
    script.push_back(byte_step(8'h00, 1'b0, 1, 64'h00));
    script.push_back(byte_step(8'hFF, 1'b1, 1, 64'hFF));
    // "abc" -> "XY", match in the middle, partial match flushed at end of file
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_BYTES, 64'h636261));
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_LENGTH, 64'd3));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5958));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd2));
    script.push_back(byte_step(8'h78, 1'b0, -1, '0));
    script.push_back(byte_step(8'h61, 1'b0, -1, '0));
    script.push_back(byte_step(8'h62, 1'b0, -1, '0));
    script.push_back(byte_step(8'h63, 1'b0, -1, '0));
    script.push_back(byte_step(8'h61, 1'b0, -1, '0));
    script.push_back(byte_step(8'h62, 1'b1, -1, '0));
    // self-overlapping "aab" against "aaab"
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_BYTES, 64'h626161));
    script.push_back(byte_step(8'h61, 1'b0, -1, '0));
    script.push_back(byte_step(8'h61, 1'b0, -1, '0));
    script.push_back(byte_step(8'h61, 1'b0, -1, '0));
    script.push_back(byte_step(8'h62, 1'b1, -1, '0));
    // zero lengths act as 1, lengths above 8 act as 8
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_LENGTH, 64'd0));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd12));
    script.push_back(byte_step(8'h61, 1'b1, -1, '0));
    // full-width pattern of 0xFF; a near miss drops all eight bytes
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_LENGTH, 64'd15));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd8));
    for (i = 0; i < 7; i++) script.push_back(byte_step(8'hFF, 1'b0, 0, '0));
    script.push_back(byte_step(8'h00, 1'b1, 8, 64'h00FF_FFFF_FFFF_FFFF));
    // pattern rewritten while a prefix is held: the held bytes are dropped
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_BYTES, 64'h636261));
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_LENGTH, 64'd3));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h21));
    script.push_back(reg_step(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0));
    script.push_back(byte_step(8'h61, 1'b0, 0, '0));
    script.push_back(byte_step(8'h62, 1'b0, 0, '0));
    script.push_back(reg_step(sfr_pkg::REG_PATTERN_LENGTH, 64'd2));
    script.push_back(byte_step(8'h63, 1'b1, -1, '0));

    // reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script
    for (i = 0; i < script.size(); i++) begin
      if (script[i].is_reg) write_reg(script[i].idx, script[i].val);
      else feed(script[i].data, script[i].eof, script[i].n_typed, script[i].typed);
    end

    // random phases, each with its own settings
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      sym_a = sfr_pkg::byte_t'($urandom_range(0, 255));
      sym_b = sfr_pkg::byte_t'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        word = {$urandom, $urandom};
      end else begin
        for (k = 0; k < 8; k++) word[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      write_reg(sfr_pkg::REG_PATTERN_BYTES, word);
      case (phase)
        0:       write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd8);
        1:       write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
        default: write_reg(sfr_pkg::REG_PATTERN_LENGTH,
                           64'(($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, 15) : $urandom_range(1, 8)));
      endcase
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      case (phase)
        0:       write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
        1:       write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
        default: write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
      endcase

      // idling for this phase; long hold-off in phase 2; none in the last
      send_gaps   = $urandom_range(0, 3) != 0;
      recv_stalls = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        send_gaps  = 1'b0;
        stall_long = 1'b1;
      end
      if (phase == RAND_PHASES - 1) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end

      // text mostly built from whole patterns, prefixes and pattern bytes
      plen = pat_len();
      text = {};
      while (text.size() < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          for (j = 0; j < plen; j++) text.push_back(pat_word[8*j +: 8]);
        end else if (pick < 6) begin
          k = (plen > 1) ? int'($urandom_range(1, plen - 1)) : 1;
          for (j = 0; j < k; j++) text.push_back(pat_word[8*j +: 8]);
        end else if (pick < 8) begin
          text.push_back(pat_word[8*$urandom_range(0, plen - 1) +: 8]);
        end else begin
          text.push_back(sfr_pkg::byte_t'($urandom_range(0, 255)));
        end
      end
      for (i = 0; i < text.size(); i++) begin
        if (i == text.size() - 1)
          eof = (phase == RAND_PHASES - 1) ? 1'b1 : 1'($urandom_range(0, 1));
        else
          eof = ($urandom_range(0, 11) == 0);
        feed(text[i], eof, -1, '0);
      end
    end

    // drain and report
    wait_idle();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/sfr_pkg.sv
src/sfr_config.sv
src/sfr_match.sv
src/sfr_emit.sv
src/stream_find_replace.sv
bench/tb.sv
